// ----- src/tew_pkg.sv -----
// ----------------------------------------------------------------------------
// tew_pkg
// Shared types, request codes and saturation helpers of the edge walker.
// ----------------------------------------------------------------------------
package tew_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int NUM_ATTRS_DEF = 5;
    localparam int OUT_ATTRS     = 5;
    localparam int MUL_W         = 33;
    localparam int PROD_W        = 2 * MUL_W;
    localparam int ACC_W         = PROD_W + 2;

    localparam logic [1:0] REQ_POS  = 2'd0;
    localparam logic [1:0] REQ_ATTR = 2'd1;
    localparam logic [1:0] REQ_STEP = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_POS_MUL,
        ST_POS_FIN,
        ST_ATT_M1,
        ST_ATT_M2,
        ST_ATT_M3,
        ST_ATT_FIN,
        ST_STEP_X,
        ST_STEP_A,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] top_x;
        logic signed [31:0] top_y;
        logic signed [31:0] bottom_x;
        logic signed [31:0] bottom_y;
        logic [2:0]         attr_sel;
        logic signed [31:0] attr_start;
        logic signed [31:0] attr_dx;
        logic signed [31:0] attr_dy;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] cur_x;
        logic signed [31:0] cur_slope;
        logic signed [15:0] first_line;
        logic signed [15:0] end_line;
        logic signed [31:0] cur_tex_u;
        logic signed [31:0] cur_tex_v;
        logic signed [31:0] cur_inv_z;
        logic signed [31:0] cur_depth;
        logic signed [31:0] cur_light;
        logic               flat_edge;
        logic               sat_flag;
    } out_item_t;

    typedef struct packed {
        logic               sat;
        logic signed [31:0] value;
    } sat32_t;

    typedef struct packed {
        logic               sat;
        logic signed [15:0] value;
    } sat16_t;

    function automatic sat32_t sat32(input logic signed [ACC_W-1:0] v);
        sat32_t r;
        if (v > ACC_W'(64'sd2147483647)) begin
            r.sat   = 1'b1;
            r.value = 32'sh7FFFFFFF;
        end
        else if (v < -ACC_W'(64'sd2147483648)) begin
            r.sat   = 1'b1;
            r.value = 32'sh80000000;
        end
        else begin
            r.sat   = 1'b0;
            r.value = v[31:0];
        end
        return r;
    endfunction

    function automatic sat16_t sat16(input logic signed [32:0] v);
        sat16_t r;
        if (v > 33'sd32767) begin
            r.sat   = 1'b1;
            r.value = 16'sh7FFF;
        end
        else if (v < -33'sd32768) begin
            r.sat   = 1'b1;
            r.value = 16'sh8000;
        end
        else begin
            r.sat   = 1'b0;
            r.value = v[15:0];
        end
        return r;
    endfunction

endpackage

// ----- src/tew_in_if.sv -----
// ----------------------------------------------------------------------------
// tew_in_if
// Request channel: valid, ready and one request word.
// ----------------------------------------------------------------------------
interface tew_in_if
    import tew_pkg::*;
();
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- src/tew_out_if.sv -----
// ----------------------------------------------------------------------------
// tew_out_if
// Result channel: valid, ready and one edge word.
// ----------------------------------------------------------------------------
interface tew_out_if
    import tew_pkg::*;
();
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- src/triangle_edge_walker_core.sv -----
// ----------------------------------------------------------------------------
// triangle_edge_walker_core
// Scanline edge setup and stepping with saturating fixed-point arithmetic.
// ----------------------------------------------------------------------------
// A position setup waits on the bit-serial slope divider (a zero-height
// edge skips the divider); an attribute setup runs in the shared
// multiplier; a step runs through the shared saturating adder, one
// attribute per cycle. The request side is ready only when the sequencer
// is idle; a finished result waits in the output register while the next
// request is taken.
module triangle_edge_walker_core
    import tew_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int NUM_ATTRS = NUM_ATTRS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    tew_in_if.sink    in_ch,
    tew_out_if.source out_ch
);
    localparam int NUM_W = 32 + FRAC_BITS;
    localparam int IDX_W = (NUM_ATTRS > 1) ? $clog2(NUM_ATTRS) : 1;

    state_t                   state_reg, state_next;
    in_item_t                 in_reg, in_next;
    logic signed [31:0]       edge_x_reg, edge_x_next;
    logic signed [31:0]       slope_reg, slope_next;
    logic signed [15:0]       line_first_reg, line_first_next;
    logic signed [15:0]       line_end_reg, line_end_next;
    logic signed [32:0]       x_pre_reg, x_pre_next;
    logic [FRAC_BITS-1:0]     y_pre_reg, y_pre_next;
    logic signed [31:0]       attr_value_reg [NUM_ATTRS];
    logic signed [31:0]       attr_value_next [NUM_ATTRS];
    logic signed [31:0]       attr_step_reg [NUM_ATTRS];
    logic signed [31:0]       attr_step_next [NUM_ATTRS];
    logic                     flat_reg, flat_next;
    logic                     sat_reg, sat_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic                     neg_reg, neg_next;
    out_item_t                out_reg, out_next;
    logic                     out_valid_reg, out_valid_next;

    logic                     div_start;
    logic                     div_done;
    logic [NUM_W-1:0]         div_num;
    logic [31:0]              div_den;
    logic [NUM_W-1:0]         div_quo;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] prod_sh;
    logic signed [ACC_W-1:0]  prod_ext;

    logic                     accept;
    logic                     load_out;
    logic signed [32:0]       ty_ext, by_ext, ydist, xdist;
    logic [32:0]              abs_x, abs_y;
    logic signed [32:0]       c_top, c_bot;
    sat16_t                   s_first, s_end;
    sat32_t                   s_a, s_b;
    logic signed [ACC_W-1:0]  sum_a, sum_b;
    logic signed [32:0]       y_pre_ext, slope_ext;

    tew_div #(.NUM_W(NUM_W), .DEN_W(32)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    tew_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    assign accept   = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || out_ch.ready);

    assign ty_ext = {in_ch.data.top_y[31], in_ch.data.top_y};
    assign by_ext = {in_ch.data.bottom_y[31], in_ch.data.bottom_y};
    assign ydist  = by_ext - ty_ext;
    assign xdist  = {in_ch.data.bottom_x[31], in_ch.data.bottom_x}
                  - {in_ch.data.top_x[31], in_ch.data.top_x};
    assign abs_x  = xdist[32] ? 33'(-xdist) : 33'(xdist);
    assign abs_y  = ydist[32] ? 33'(-ydist) : 33'(ydist);
    assign c_top  = (ty_ext + 33'((1 << FRAC_BITS) - 1)) >>> FRAC_BITS;
    assign c_bot  = (by_ext + 33'((1 << FRAC_BITS) - 1)) >>> FRAC_BITS;
    assign s_first = sat16(c_top);
    assign s_end   = sat16(c_bot);

    assign div_num = {abs_x[31:0], {FRAC_BITS{1'b0}}};
    assign div_den = abs_y[31:0];

    assign y_pre_ext = {{(33 - FRAC_BITS){1'b0}}, y_pre_reg};
    assign slope_ext = {slope_reg[31], slope_reg};
    assign prod_sh   = prod >>> FRAC_BITS;
    assign prod_ext  = {{(ACC_W - PROD_W){prod_sh[PROD_W-1]}}, prod_sh};

    // shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_POS_MUL:
            begin
                mul_a = y_pre_ext;
                mul_b = slope_ext;
            end
            ST_ATT_M1:
            begin
                mul_a = {in_reg.attr_dx[31], in_reg.attr_dx};
                mul_b = x_pre_reg;
            end
            ST_ATT_M2:
            begin
                mul_a = {in_reg.attr_dy[31], in_reg.attr_dy};
                mul_b = y_pre_ext;
            end
            ST_ATT_M3:
            begin
                mul_a = {in_reg.attr_dx[31], in_reg.attr_dx};
                mul_b = slope_ext;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_ch.data.req_type)
                        REQ_POS:  state_next = (ydist == '0) ? ST_POS_MUL : ST_DIV;
                        REQ_ATTR: state_next = ({1'b0, in_ch.data.attr_sel} < 4'(NUM_ATTRS))
                                             ? ST_ATT_M1 : ST_DONE;
                        REQ_STEP: state_next = ST_STEP_X;
                        default:  state_next = ST_DONE;
                    endcase
                end
            end
            ST_DIV:     state_next = div_done ? ST_POS_MUL : ST_DIV;
            ST_POS_MUL: state_next = ST_POS_FIN;
            ST_POS_FIN: state_next = ST_DONE;
            ST_ATT_M1:  state_next = ST_ATT_M2;
            ST_ATT_M2:  state_next = ST_ATT_M3;
            ST_ATT_M3:  state_next = ST_ATT_FIN;
            ST_ATT_FIN: state_next = ST_DONE;
            ST_STEP_X:  state_next = ST_STEP_A;
            ST_STEP_A:  state_next = (idx_reg == IDX_W'(NUM_ATTRS - 1)) ? ST_DONE : ST_STEP_A;
            ST_DONE:    state_next = load_out ? ST_IDLE : ST_DONE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        in_next         = in_reg;
        edge_x_next     = edge_x_reg;
        slope_next      = slope_reg;
        line_first_next = line_first_reg;
        line_end_next   = line_end_reg;
        x_pre_next      = x_pre_reg;
        y_pre_next      = y_pre_reg;
        attr_value_next = attr_value_reg;
        attr_step_next  = attr_step_reg;
        flat_next       = flat_reg;
        sat_next        = sat_reg;
        idx_next        = idx_reg;
        acc_next        = acc_reg;
        neg_next        = neg_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        div_start       = 1'b0;
        sum_a           = '0;
        sum_b           = '0;
        s_a             = '0;
        s_b             = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    in_next  = in_ch.data;
                    sat_next = 1'b0;
                    idx_next = in_ch.data.attr_sel[IDX_W-1:0];
                    if (in_ch.data.req_type == REQ_POS)
                    begin
                        line_first_next = s_first.value;
                        line_end_next   = s_end.value;
                        sat_next        = s_first.sat | s_end.sat;
                        y_pre_next      = FRAC_BITS'(-in_ch.data.top_y);
                        neg_next        = xdist[32] ^ ydist[32];
                        if (ydist == '0)
                        begin
                            slope_next = '0;
                            flat_next  = 1'b1;
                        end
                        else
                        begin
                            flat_next = 1'b0;
                            div_start = 1'b1;
                        end
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    if (neg_reg)
                    begin
                        if (div_quo > NUM_W'(33'h080000000))
                        begin
                            slope_next = 32'sh80000000;
                            sat_next   = 1'b1;
                        end
                        else
                        begin
                            slope_next = -div_quo[31:0];
                        end
                    end
                    else
                    begin
                        if (div_quo > NUM_W'(33'h07FFFFFFF))
                        begin
                            slope_next = 32'sh7FFFFFFF;
                            sat_next   = 1'b1;
                        end
                        else
                        begin
                            slope_next = div_quo[31:0];
                        end
                    end
                end
            end
            ST_POS_FIN:
            begin
                sum_a       = {{(ACC_W - 32){in_reg.top_x[31]}}, in_reg.top_x} + prod_ext;
                s_a         = sat32(sum_a);
                edge_x_next = s_a.value;
                x_pre_next  = {s_a.value[31], s_a.value} - {in_reg.top_x[31], in_reg.top_x};
                sat_next    = sat_reg | s_a.sat;
            end
            ST_ATT_M2:
            begin
                acc_next = {{(ACC_W - 32){in_reg.attr_start[31]}}, in_reg.attr_start} + prod_ext;
            end
            ST_ATT_M3:
            begin
                acc_next = acc_reg + prod_ext;
            end
            ST_ATT_FIN:
            begin
                s_a   = sat32(acc_reg);
                sum_b = {{(ACC_W - 32){in_reg.attr_dy[31]}}, in_reg.attr_dy} + prod_ext;
                s_b   = sat32(sum_b);
                attr_value_next[idx_reg] = s_a.value;
                attr_step_next[idx_reg]  = s_b.value;
                sat_next = sat_reg | s_a.sat | s_b.sat;
            end
            ST_STEP_X:
            begin
                sum_a = {{(ACC_W - 32){edge_x_reg[31]}}, edge_x_reg}
                      + {{(ACC_W - 32){slope_reg[31]}}, slope_reg};
                s_a         = sat32(sum_a);
                edge_x_next = s_a.value;
                sat_next    = sat_reg | s_a.sat;
                idx_next    = '0;
            end
            ST_STEP_A:
            begin
                sum_a = {{(ACC_W - 32){attr_value_reg[idx_reg][31]}}, attr_value_reg[idx_reg]}
                      + {{(ACC_W - 32){attr_step_reg[idx_reg][31]}}, attr_step_reg[idx_reg]};
                s_a = sat32(sum_a);
                attr_value_next[idx_reg] = s_a.value;
                sat_next = sat_reg | s_a.sat;
                idx_next = idx_reg + 1'b1;
            end
            default:
            begin
                sum_a = '0;
            end
        endcase

        if (load_out)
        begin
            out_next.cur_x      = edge_x_reg;
            out_next.cur_slope  = slope_reg;
            out_next.first_line = line_first_reg;
            out_next.end_line   = line_end_reg;
            out_next.cur_tex_u  = (NUM_ATTRS > 0) ? attr_value_reg[0] : '0;
            out_next.cur_tex_v  = (NUM_ATTRS > 1) ? attr_value_reg[(NUM_ATTRS > 1) ? 1 : 0] : '0;
            out_next.cur_inv_z  = (NUM_ATTRS > 2) ? attr_value_reg[(NUM_ATTRS > 2) ? 2 : 0] : '0;
            out_next.cur_depth  = (NUM_ATTRS > 3) ? attr_value_reg[(NUM_ATTRS > 3) ? 3 : 0] : '0;
            out_next.cur_light  = (NUM_ATTRS > 4) ? attr_value_reg[(NUM_ATTRS > 4) ? 4 : 0] : '0;
            out_next.flat_edge  = flat_reg;
            out_next.sat_flag   = sat_reg;
            out_valid_next      = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            edge_x_reg     <= '0;
            slope_reg      <= '0;
            line_first_reg <= '0;
            line_end_reg   <= '0;
            x_pre_reg      <= '0;
            y_pre_reg      <= '0;
            flat_reg       <= 1'b0;
            sat_reg        <= 1'b0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < NUM_ATTRS; i++)
            begin
                attr_value_reg[i] <= '0;
                attr_step_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            edge_x_reg     <= edge_x_next;
            slope_reg      <= slope_next;
            line_first_reg <= line_first_next;
            line_end_reg   <= line_end_next;
            x_pre_reg      <= x_pre_next;
            y_pre_reg      <= y_pre_next;
            flat_reg       <= flat_next;
            sat_reg        <= sat_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
            attr_value_reg <= attr_value_next;
            attr_step_reg  <= attr_step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg  <= in_next;
        acc_reg <= acc_next;
        neg_reg <= neg_next;
        out_reg <= out_next;
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;
endmodule

// ----- src/tew_div.sv -----
// ----------------------------------------------------------------------------
// tew_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tew_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[NUM_W-1]};
        diff      = shifted - {1'b0, den_reg};
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            quo_next = num;
            den_next = den;
        end
        else if (run_reg)
        begin
            if (!diff[DEN_W])
            begin
                rem_next = diff[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;
endmodule

// ----- src/tew_mul.sv -----
// ----------------------------------------------------------------------------
// tew_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module tew_mul
    import tew_pkg::*;
(
    input  logic                     clk,
    input  logic signed [MUL_W-1:0]  a,
    input  logic signed [MUL_W-1:0]  b,
    output logic signed [PROD_W-1:0] p
);
    logic signed [PROD_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;
endmodule
